>>> hdl/wbps_pkg.sv
package wbps_pkg;

  // Window and pattern geometry.
  localparam int MAX_PATTERN = 32;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int BYTE_W      = 8;

  // Offset counter and result offset widths.
  localparam int OFFSET_BITS = 32;
  localparam int OUT_OFF_W   = 32;

  // Configuration port geometry.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PAT_WORDS   = 4;
  localparam int WORD_BYTES  = CFG_DATA_W / BYTE_W;
  localparam int CARE_W      = 32;
  localparam int LEN_REG_W   = 6;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAT_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd5;

  // Highest value of the offset counter.
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_vec_t;

endpackage

>>> hdl/wbps_if.sv
// Byte stream channel into the scanner.
interface wbps_in_if;
  logic                         valid;
  logic                         ready;
  logic [wbps_pkg::BYTE_W-1:0]  data_byte;
  logic                         region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

// Scan result channel out of the scanner.
interface wbps_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [wbps_pkg::OUT_OFF_W-1:0]  match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

>>> hdl/wbps_match.sv
// Masked compare of the byte window against the pattern. Window position 0
// holds the newest byte; pattern byte (length - 1 - j) lines up with window
// position j.
module wbps_match (
  input  wbps_pkg::byte_vec_t               window_i,
  input  wbps_pkg::byte_vec_t               pattern_i,
  input  logic [wbps_pkg::CARE_W-1:0]       care_i,
  input  logic [wbps_pkg::LEN_REG_W-1:0]    length_i,
  input  logic [wbps_pkg::OFFSET_BITS-1:0]  count_i,
  output logic                              match_o
);
  import wbps_pkg::*;

  logic [MAX_PATTERN-1:0] pos_ok;
  logic                   len_ok;

  // Per-position compare: positions beyond the length and wildcards pass.
  always_comb begin
    logic [LEN_REG_W-1:0] idx_full;
    logic [IDX_W-1:0]     idx;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      idx_full = length_i - LEN_REG_W'(1) - LEN_REG_W'(j);
      idx      = idx_full[IDX_W-1:0];
      if (LEN_REG_W'(j) >= length_i) begin
        pos_ok[j] = 1'b1;
      end else begin
        pos_ok[j] = !care_i[idx] || (window_i[j] == pattern_i[idx]);
      end
    end
  end

  // Length must be in range and the region must already hold that many bytes.
  assign len_ok = (length_i != '0) &&
                  (length_i <= LEN_REG_W'(MAX_PATTERN)) &&
                  (count_i >= OFFSET_BITS'(length_i));

  assign match_o = len_ok && (&pos_ok);

endmodule

>>> hdl/wildcard_byte_pattern_scanner.sv
// Wildcard byte pattern scanner.
// The region to be scanned arrives on in_i, one byte per transaction, with
// region_end set on its last byte. The first time the most recent
// pattern_length bytes match the pattern on every position whose care bit is
// set, one result with found = 1 and the start offset of the match goes out on
// out_o; further matches in that region are dropped. If the last byte passes
// without a match, one result with found = 0 and offset zero goes out.
// Configuration must be written through cfg_we_i / cfg_idx_i / cfg_wdata_i only
// while idle, which the block does not enforce; indexes past the pattern length
// register are ignored. Throughput is one byte per cycle unless a result stalls:
// the window compare is a single level of parallel byte comparators between the
// window and result registers. A result appears on out_o the cycle after its
// byte is accepted. The result register frees in_i as soon as the downstream
// side takes the result, so a stalled receiver holds input only while a result
// is pending. Reset clears the configuration, the window, the offset counter
// and the result valid bit; the next byte after reset or after region_end
// starts a new region. The offset counter saturates at its maximum value.
module wildcard_byte_pattern_scanner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  wbps_in_if.sink                           in_i,
  wbps_out_if.source                        out_o
);
  import wbps_pkg::*;

  // Configuration registers.
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_words_q;
  logic [CARE_W-1:0]                    care_q;
  logic [LEN_REG_W-1:0]                 length_q;

  // Region state.
  byte_vec_t                window_q, window_d;
  logic [OFFSET_BITS-1:0]   seen_q, seen_d;
  logic                     reported_q, reported_d;

  // Result register.
  logic                     out_valid_q, out_valid_d;
  logic                     found_q, found_d;
  logic [OUT_OFF_W-1:0]     offset_q, offset_d;

  byte_vec_t                pattern;
  logic                     in_fire;
  logic                     match;
  logic                     emit;
  logic [OFFSET_BITS-1:0]   match_off;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_words_q <= '0;
      care_q      <= '0;
      length_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAT_A:  pat_words_q[0] <= cfg_wdata_i;
        REG_PAT_B:  pat_words_q[1] <= cfg_wdata_i;
        REG_PAT_C:  pat_words_q[2] <= cfg_wdata_i;
        REG_PAT_D:  pat_words_q[3] <= cfg_wdata_i;
        REG_CARE:   care_q         <= cfg_wdata_i[CARE_W-1:0];
        REG_LENGTH: length_q       <= cfg_wdata_i[LEN_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  // Unpack the pattern words into bytes, byte 0 in the low bits of word 0.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pattern[i] = pat_words_q[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
    end
  end

  // Handshake: the input moves whenever the result register is free or drains.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Window shifts in the new byte; the counter saturates.
  always_comb begin
    window_d = {window_q[MAX_PATTERN-2:0], in_i.data_byte};
    seen_d   = (seen_q != COUNT_MAX) ? seen_q + OFFSET_BITS'(1) : COUNT_MAX;
  end

  wbps_match u_match (
    .window_i  (window_d),
    .pattern_i (pattern),
    .care_i    (care_q),
    .length_i  (length_q),
    .count_i   (seen_d),
    .match_o   (match)
  );

  assign match_off = seen_d - OFFSET_BITS'(length_q);

  // Result selection: first match, else a miss on the last byte.
  always_comb begin
    emit     = 1'b0;
    found_d  = found_q;
    offset_d = offset_q;
    priority if (!reported_q && match) begin
      emit     = 1'b1;
      found_d  = 1'b1;
      offset_d = OUT_OFF_W'(match_off);
    end else if (!reported_q && in_i.region_end) begin
      emit     = 1'b1;
      found_d  = 1'b0;
      offset_d = '0;
    end
    reported_d = reported_q || (!reported_q && match);
  end

  // Output valid follows the accepted byte, or clears once taken.
  always_comb begin
    if (in_fire) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Region state update; region end starts over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (in_fire) begin
      window_q <= window_d;
      if (in_i.region_end) begin
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else begin
        seen_q     <= seen_d;
        reported_q <= reported_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      found_q  <= found_d;
      offset_q <= offset_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = found_q;
  assign out_o.match_offset = offset_q;

  // A not-found result always carries a zero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> offset_q == '0)
    else $error("not-found result with nonzero offset");

  // A region end clears the counter and the reported flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.region_end |=> seen_q == '0 && !reported_q)
    else $error("region state not cleared at region end");

  // A stalled result is held in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(found_q) && $stable(offset_q))
    else $error("pending result changed while stalled");

  // A found result mid-region blocks any further result in that region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && emit && found_d && !in_i.region_end |=> reported_q)
    else $error("match not recorded as reported");

endmodule
